// ===== rtl/dfca_pkg.sv =====
package dfca_pkg;

    localparam int AUX_MAX     = 1024;
    localparam int AUX_AW      = $clog2(AUX_MAX);
    localparam int IDX_W       = 10;
    localparam int CNT_W       = 11;
    localparam int DBL_W       = 64;
    localparam int QUEUE_DEPTH = 2;     // power of two, pointers wrap naturally
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CNT_W-1:0] AUX_COUNT_RESET = CNT_W'(1024);
    localparam logic [DBL_W-1:0] FP_TWO          = 64'h4000_0000_0000_0000;
    localparam logic [DBL_W-1:0] FP_POS_ZERO     = 64'h0000_0000_0000_0000;

    typedef enum logic {
        OP_ACCUM = 1'b0,
        OP_DOT   = 1'b1
    } item_op_t;

    typedef enum logic {
        FPU_MUL = 1'b0,
        FPU_ADD = 1'b1
    } fpu_op_t;

    typedef enum logic [2:0] {
        FPU_IDLE,
        FPU_MULT,
        FPU_ALIGN,
        FPU_SUM,
        FPU_NORM,
        FPU_ROUND
    } fpu_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_FETCH,
        B_START,
        B_DBL_WAIT,
        B_PROD_WAIT,
        B_SUM_WAIT,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        item_op_t               op;
        logic                   first_pair;
        logic                   off_diagonal;
        logic                   in_range;
        logic                   row_last;
        logic [IDX_W-1:0]       aux_index;
        logic [DBL_W-1:0]       density;
        logic [DBL_W-1:0]       tensor_value;
    } item_t;

    typedef struct packed {
        logic             start;
        fpu_op_t          op;
        logic [DBL_W-1:0] a;
        logic [DBL_W-1:0] b;
    } fpu_req_t;

    typedef struct packed {
        logic             done;
        logic [DBL_W-1:0] result;
    } fpu_rsp_t;

endpackage

// ===== rtl/dfca_ram.sv =====
module dfca_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/dfca_fpu.sv =====
// Shared double-precision multiply / add unit, round to nearest even.
// Multiply: four 27x27 partial products, one per cycle, each added to the accumulator in the following cycle.
module dfca_fpu
    import dfca_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  fpu_req_t req,
    output fpu_rsp_t rsp
);

    localparam logic [DBL_W-1:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
    localparam logic [DBL_W-1:0] QUIET_BIT   = 64'h0008_0000_0000_0000;

    function automatic logic is_nan(input logic [DBL_W-1:0] x);
        return (x[62:52] == 11'h7FF) && (x[51:0] != '0);
    endfunction

    function automatic logic is_inf(input logic [DBL_W-1:0] x);
        return (x[62:52] == 11'h7FF) && (x[51:0] == '0);
    endfunction

    function automatic logic is_zero(input logic [DBL_W-1:0] x);
        return x[62:0] == '0;
    endfunction

    function automatic logic [10:0] unp_exp(input logic [DBL_W-1:0] x);
        return (x[62:52] == '0) ? 11'd1 : x[62:52];
    endfunction

    function automatic logic [52:0] unp_man(input logic [DBL_W-1:0] x);
        return {(x[62:52] != '0), x[51:0]};
    endfunction

    fpu_state_t         state_reg, state_next;
    logic               done_reg, done_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic               sa_reg, sa_next, sb_reg, sb_next;
    logic [10:0]        ea_reg, ea_next, eb_reg, eb_next;
    logic [52:0]        ma_reg, ma_next, mb_reg, mb_next;
    logic [53:0]        pp_reg, pp_next;
    logic [1:0]         pp_sh_reg, pp_sh_next;
    logic [107:0]       acc_reg, acc_next;
    logic [107:0]       xm_reg, xm_next, ym_reg, ym_next;
    logic               sx_reg, sx_next, sy_reg, sy_next;
    logic [107:0]       nm_reg, nm_next;
    logic signed [13:0] ne_reg, ne_next;
    logic               sign_reg, sign_next;
    logic               right_reg, right_next;
    logic [DBL_W-1:0]   res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FPU_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sa_reg    <= sa_next;
        sb_reg    <= sb_next;
        ea_reg    <= ea_next;
        eb_reg    <= eb_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        pp_reg    <= pp_next;
        pp_sh_reg <= pp_sh_next;
        acc_reg   <= acc_next;
        xm_reg    <= xm_next;
        ym_reg    <= ym_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        nm_reg    <= nm_next;
        ne_reg    <= ne_next;
        sign_reg  <= sign_next;
        right_reg <= right_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        logic [26:0]        ai;
        logic [26:0]        bi;
        logic [107:0]       pp_ext;
        logic [107:0]       pp_shifted;
        logic [107:0]       acc_sum;
        logic               swap;
        logic [10:0]        ebig;
        logic [10:0]        d;
        logic [52:0]        mbig;
        logic [52:0]        msmall;
        logic [107:0]       yfull;
        logic [107:0]       lost_mask;
        logic [52:0]        mant;
        logic               up;
        logic [53:0]        m1;
        logic signed [13:0] e1;
        logic [52:0]        mfin;

        state_next = state_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        sa_next    = sa_reg;
        sb_next    = sb_reg;
        ea_next    = ea_reg;
        eb_next    = eb_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        pp_next    = pp_reg;
        pp_sh_next = pp_sh_reg;
        acc_next   = acc_reg;
        xm_next    = xm_reg;
        ym_next    = ym_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        nm_next    = nm_reg;
        ne_next    = ne_reg;
        sign_next  = sign_reg;
        right_next = right_reg;
        res_next   = res_reg;

        ai = cnt_reg[1] ? {1'b0, ma_reg[52:27]} : ma_reg[26:0];
        bi = cnt_reg[0] ? {1'b0, mb_reg[52:27]} : mb_reg[26:0];
        pp_ext = {54'b0, pp_reg};
        case (pp_sh_reg)
            2'd0:    pp_shifted = pp_ext;
            2'd1:    pp_shifted = pp_ext << 27;
            default: pp_shifted = pp_ext << 54;
        endcase
        acc_sum = acc_reg + pp_shifted;

        swap   = eb_reg > ea_reg;
        ebig   = swap ? eb_reg : ea_reg;
        d      = swap ? (eb_reg - ea_reg) : (ea_reg - eb_reg);
        mbig   = swap ? mb_reg : ma_reg;
        msmall = swap ? ma_reg : mb_reg;
        yfull  = {1'b0, msmall, 54'b0};
        lost_mask = ~({108{1'b1}} << d);

        mant = nm_reg[107:55];
        up   = nm_reg[54] & ((|nm_reg[53:0]) | mant[0]);
        m1   = {1'b0, mant} + 54'(up);
        e1   = ne_reg + $signed({13'b0, m1[53]});
        mfin = m1[53] ? m1[53:1] : m1[52:0];

        unique case (state_reg)
            FPU_IDLE:
            begin
                if (req.start)
                begin
                    sa_next = req.a[63];
                    sb_next = req.b[63];
                    ea_next = unp_exp(req.a);
                    eb_next = unp_exp(req.b);
                    ma_next = unp_man(req.a);
                    mb_next = unp_man(req.b);
                    if (is_nan(req.a))
                    begin
                        res_next  = req.a | QUIET_BIT;
                        done_next = 1'b1;
                    end
                    else if (is_nan(req.b))
                    begin
                        res_next  = req.b | QUIET_BIT;
                        done_next = 1'b1;
                    end
                    else if (req.op == FPU_MUL)
                    begin
                        if ((is_inf(req.a) && is_zero(req.b)) ||
                            (is_zero(req.a) && is_inf(req.b)))
                        begin
                            res_next  = DEFAULT_NAN;
                            done_next = 1'b1;
                        end
                        else if (is_inf(req.a) || is_inf(req.b))
                        begin
                            res_next  = {req.a[63] ^ req.b[63], 11'h7FF, 52'b0};
                            done_next = 1'b1;
                        end
                        else
                        begin
                            acc_next   = '0;
                            cnt_next   = '0;
                            sign_next  = req.a[63] ^ req.b[63];
                            state_next = FPU_MULT;
                        end
                    end
                    else
                    begin
                        if (is_inf(req.a) && is_inf(req.b) && (req.a[63] != req.b[63]))
                        begin
                            res_next  = DEFAULT_NAN;
                            done_next = 1'b1;
                        end
                        else if (is_inf(req.a))
                        begin
                            res_next  = req.a;
                            done_next = 1'b1;
                        end
                        else if (is_inf(req.b))
                        begin
                            res_next  = req.b;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            state_next = FPU_ALIGN;
                        end
                    end
                end
            end

            FPU_MULT:
            begin
                if (cnt_reg != 3'd0)
                begin
                    acc_next = acc_sum;
                end
                if (cnt_reg != 3'd4)
                begin
                    pp_next    = ai * bi;
                    pp_sh_next = 2'(cnt_reg[1]) + 2'(cnt_reg[0]);
                    cnt_next   = cnt_reg + 3'd1;
                end
                else
                begin
                    nm_next    = {acc_sum[105:0], 2'b00};
                    ne_next    = $signed({3'b0, ea_reg}) + $signed({3'b0, eb_reg})
                                 - 14'sd1022;
                    right_next = 1'b0;
                    state_next = FPU_NORM;
                end
            end

            FPU_ALIGN:
            begin
                xm_next = {1'b0, mbig, 54'b0};
                if (d >= 11'd108)
                begin
                    ym_next = {107'b0, |msmall};
                end
                else
                begin
                    ym_next = (yfull >> d) | {107'b0, |(yfull & lost_mask)};
                end
                sx_next    = swap ? sb_reg : sa_reg;
                sy_next    = swap ? sa_reg : sb_reg;
                ne_next    = $signed({3'b0, ebig}) + 14'sd1;
                state_next = FPU_SUM;
            end

            FPU_SUM:
            begin
                if (sx_reg == sy_reg)
                begin
                    nm_next   = xm_reg + ym_reg;
                    sign_next = sx_reg;
                end
                else if (xm_reg >= ym_reg)
                begin
                    nm_next   = xm_reg - ym_reg;
                    // exact cancellation gives +0 under round to nearest
                    sign_next = (xm_reg == ym_reg) ? 1'b0 : sx_reg;
                end
                else
                begin
                    nm_next   = ym_reg - xm_reg;
                    sign_next = sy_reg;
                end
                right_next = 1'b0;
                state_next = FPU_NORM;
            end

            FPU_NORM:
            begin
                // left-justify first, then denormalize back to the minimum exponent
                if (nm_reg == '0)
                begin
                    state_next = FPU_ROUND;
                end
                else if (!right_reg && !nm_reg[107])
                begin
                    if (nm_reg[107:92] == '0)
                    begin
                        nm_next = nm_reg << 16;
                        ne_next = ne_reg - 14'sd16;
                    end
                    else
                    begin
                        nm_next = nm_reg << 1;
                        ne_next = ne_reg - 14'sd1;
                    end
                end
                else if (ne_reg < 14'sd1)
                begin
                    right_next = 1'b1;
                    if (ne_reg < -14'sd119)
                    begin
                        nm_next = {107'b0, 1'b1};
                        ne_next = 14'sd1;
                    end
                    else if (ne_reg < -14'sd14)
                    begin
                        nm_next = (nm_reg >> 16) | {107'b0, |nm_reg[15:0]};
                        ne_next = ne_reg + 14'sd16;
                    end
                    else
                    begin
                        nm_next = (nm_reg >> 1) | {107'b0, nm_reg[0]};
                        ne_next = ne_reg + 14'sd1;
                    end
                end
                else
                begin
                    state_next = FPU_ROUND;
                end
            end

            FPU_ROUND:
            begin
                if (mfin[52] && (e1 > 14'sd2046))
                begin
                    res_next = {sign_reg, 11'h7FF, 52'b0};
                end
                else
                begin
                    res_next = {sign_reg, (mfin[52] ? e1[10:0] : 11'b0), mfin[51:0]};
                end
                done_next  = 1'b1;
                state_next = FPU_IDLE;
            end

            default:
            begin
                state_next = FPU_IDLE;
            end
        endcase
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> (state_reg == FPU_IDLE))
        else $error("fpu started while busy");

endmodule

// ===== rtl/dfca_front.sv =====
// Accepts transactions, range-checks the index, queues them for the back end.
module dfca_front
    import dfca_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             operation,
    input  logic             first_pair,
    input  logic             off_diagonal,
    input  logic [DBL_W-1:0] density,
    input  logic [DBL_W-1:0] tensor_value,
    input  logic [IDX_W-1:0] aux_index,
    input  logic             row_last,
    output item_t            q_item,
    output logic             q_valid,
    input  logic             q_pop
);

    logic [CNT_W-1:0]  aux_count_reg;
    item_t             ent_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    item_t             item_in;

    assign in_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_item   = ent_reg[rd_ptr_reg];

    always_comb
    begin
        item_in.op           = item_op_t'(operation);
        item_in.first_pair   = first_pair;
        item_in.off_diagonal = off_diagonal;
        item_in.in_range     = ({1'b0, aux_index} < aux_count_reg) &&
                               (32'(aux_index) < 32'(AUX_MAX));
        item_in.row_last     = row_last;
        item_in.aux_index    = aux_index;
        item_in.density      = density;
        item_in.tensor_value = tensor_value;
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aux_count_reg <= AUX_COUNT_RESET;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                aux_count_reg <= cfg_wdata;
            end
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= item_in;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue overfilled");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

// ===== rtl/dfca_back.sv =====
// Sequences one queued transaction at a time through the shared FP unit,
// the auxiliary store and the running row sum.
module dfca_back
    import dfca_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  item_t            q_item,
    input  logic             q_valid,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [DBL_W-1:0] coulomb_value
);

    back_state_t       state_reg, state_next;
    item_t             item_reg, item_next;
    logic [DBL_W-1:0]  sum_reg, sum_next;
    logic [DBL_W-1:0]  out_data_reg, out_data_next;
    logic              out_valid_reg, out_valid_next;
    fpu_req_t          fpu_req;
    fpu_rsp_t          fpu_rsp;
    logic              ram_we;
    logic [AUX_AW-1:0] ram_addr;
    logic [DBL_W-1:0]  ram_rdata;

    assign ram_addr = AUX_AW'(item_reg.aux_index);

    dfca_fpu u_fpu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fpu_req),
        .rsp   (fpu_rsp)
    );

    dfca_ram #(
        .WIDTH (DBL_W),
        .DEPTH (AUX_MAX)
    ) u_aux_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (fpu_rsp.result),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            sum_reg       <= FP_POS_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        sum_next       = sum_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        fpu_req.start  = 1'b0;
        fpu_req.op     = FPU_MUL;
        fpu_req.a      = item_reg.density;
        fpu_req.b      = item_reg.tensor_value;

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    state_next = B_FETCH;
                end
            end

            B_FETCH:
            begin
                // store read is in flight for the latched index
                state_next = B_START;
            end

            B_START:
            begin
                if (item_reg.op == OP_ACCUM)
                begin
                    if (!item_reg.in_range)
                    begin
                        state_next = B_IDLE;
                    end
                    else if (item_reg.off_diagonal)
                    begin
                        fpu_req.start = 1'b1;
                        fpu_req.b     = FP_TWO;
                        state_next    = B_DBL_WAIT;
                    end
                    else
                    begin
                        fpu_req.start = 1'b1;
                        state_next    = B_PROD_WAIT;
                    end
                end
                else
                begin
                    if (item_reg.in_range)
                    begin
                        fpu_req.start = 1'b1;
                        fpu_req.a     = ram_rdata;
                        state_next    = B_PROD_WAIT;
                    end
                    else if (item_reg.row_last)
                    begin
                        state_next = B_EMIT;
                    end
                    else
                    begin
                        state_next = B_IDLE;
                    end
                end
            end

            B_DBL_WAIT:
            begin
                if (fpu_rsp.done)
                begin
                    fpu_req.start = 1'b1;
                    fpu_req.a     = fpu_rsp.result;
                    state_next    = B_PROD_WAIT;
                end
            end

            B_PROD_WAIT:
            begin
                if (fpu_rsp.done)
                begin
                    fpu_req.start = 1'b1;
                    fpu_req.op    = FPU_ADD;
                    fpu_req.b     = fpu_rsp.result;
                    if (item_reg.op == OP_ACCUM)
                    begin
                        fpu_req.a = item_reg.first_pair ? FP_POS_ZERO : ram_rdata;
                    end
                    else
                    begin
                        fpu_req.a = sum_reg;
                    end
                    state_next = B_SUM_WAIT;
                end
            end

            B_SUM_WAIT:
            begin
                if (fpu_rsp.done)
                begin
                    if (item_reg.op == OP_ACCUM)
                    begin
                        ram_we     = 1'b1;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        sum_next   = fpu_rsp.result;
                        state_next = item_reg.row_last ? B_EMIT : B_IDLE;
                    end
                end
            end

            B_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next  = sum_reg;
                    out_valid_next = 1'b1;
                    sum_next       = FP_POS_ZERO;
                    state_next     = B_IDLE;
                end
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign coulomb_value = out_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (item_reg.op == OP_ACCUM) && item_reg.in_range)
        else $error("store write outside an in-range accumulate");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE) && q_valid |=> (state_reg == B_FETCH))
        else $error("queued transaction not taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        fpu_rsp.done |-> (state_reg == B_DBL_WAIT) || (state_reg == B_PROD_WAIT) ||
                         (state_reg == B_SUM_WAIT))
        else $error("fpu result with no waiter");

endmodule

// ===== rtl/density_fit_coulomb_accumulate_dot.sv =====
// Density-fitting Coulomb build engine. Input transactions carry one auxiliary
// tensor element each: operation 0 adds weight*tensor_value into the 1024-entry
// auxiliary store at aux_index (weight = density, doubled when off_diagonal;
// first_pair rewrites the entry as +0 + product), operation 1 multiplies the
// element by the stored entry and adds it to a running row sum, emitting the sum
// as coulomb_value on row_last and restarting from +0. Indices at or above
// aux_count (cfg_we/cfg_wdata, reset 1024) are skipped, but a dot row_last still
// emits. All math is IEEE double, round to nearest even, with full subnormal
// support. A two-entry queue decouples input from the sequencer, and a result
// register decouples the output, so input keeps flowing while a result waits.
// Throughput is set by the single shared FP multiply/add unit that every
// in-range transaction passes through twice (three times for an off-diagonal
// accumulate): a multiply is built from four 27x27 partial products, and
// subnormal operands or results that need long normalization shifts take
// longer. The sequencer takes no new transaction until the current one is done.
// An entry must be written in the accumulate pass before the dot pass reads it;
// the store has no reset.
module density_fit_coulomb_accumulate_dot
    import dfca_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             operation,
    input  logic             first_pair,
    input  logic             off_diagonal,
    input  logic [DBL_W-1:0] density,
    input  logic [DBL_W-1:0] tensor_value,
    input  logic [IDX_W-1:0] aux_index,
    input  logic             row_last,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [DBL_W-1:0] coulomb_value
);

    item_t q_item;
    logic  q_valid;
    logic  q_pop;

    // front end: config register, range check, transaction queue
    dfca_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .first_pair   (first_pair),
        .off_diagonal (off_diagonal),
        .density      (density),
        .tensor_value (tensor_value),
        .aux_index    (aux_index),
        .row_last     (row_last),
        .q_item       (q_item),
        .q_valid      (q_valid),
        .q_pop        (q_pop)
    );

    // back end: sequencer, shared FP unit, auxiliary store, row sum, result reg
    dfca_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_item        (q_item),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .coulomb_value (coulomb_value)
    );

endmodule
